// ----- hw/rtl/crpd_pkg.sv -----
// ----------------------------------------------------------------------------
// crpd_pkg
// Shared types and constants of the cell run-length pixel decoder.
// ----------------------------------------------------------------------------
package crpd_pkg;

  localparam int unsigned MAX_WIDTH  = 320;
  localparam int unsigned MAX_HEIGHT = 200;

  localparam logic [7:0] SKIP_HDR_MIN = 8'hC0;
  localparam logic [7:0] SKIP_MASK    = 8'h3F;
  localparam logic [7:0] RUN_HDR_MIN  = 8'h80;
  localparam logic [7:0] COUNT_MASK   = 8'h7F;

  // Control from the sequencer to the raster position unit.
  typedef struct packed {
    logic       clear;    // start of a new cell: reset position, load size
    logic [8:0] width;
    logic [7:0] height;
    logic       advance;  // one pixel was emitted
  } pos_ctrl_t;

  // Status from the raster position unit.
  typedef struct packed {
    logic [8:0] col;
    logic [7:0] row;
    logic       done;       // cell area already complete
    logic       full_next;  // the pixel at col/row completes the area
  } pos_stat_t;

endpackage

// ----- hw/rtl/cell_rle_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// cell_rle_pixel_decoder_top
// Byte-serial run-length sprite cell decoder, one pixel per unstalled cycle.
// ----------------------------------------------------------------------------
// The byte transfer loads the count and value; each pixel then moves into the
// output register when a slot is free, one pixel per cycle while the sink takes
// them. The input is held while a byte's pixels are emitted; headers that emit
// nothing leave the sequencer idle, and a byte whose pixels are all dropped
// because the cell is full still passes through the emit state.
// Reset: asynchronous, active low; parser expects a header, 1 by 1 cell.
module cell_rle_pixel_decoder_top import crpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // background color register
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // coded byte stream
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_cell_i,
  input  logic [8:0] cell_width_i,
  input  logic [7:0] cell_height_i,
  input  logic [7:0] data_byte_i,
  // pixel stream
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_value_o,
  output logic [8:0] pixel_x_o,
  output logic [7:0] pixel_y_o,
  output logic       last_of_item_o,
  output logic       cell_full_o
);

  // Sequencer: idle waits for a byte, emit pushes one pixel per free slot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } seq_state_e;

  // Parser mode: what the next byte means.
  typedef enum logic [2:0] {
    MODE_HEADER  = 3'b001,
    MODE_RUNVAL  = 3'b010,
    MODE_LITERAL = 3'b100
  } parse_mode_e;

  seq_state_e  state_q, state_d;
  parse_mode_e mode_q, mode_d, mode_eff;
  logic [6:0]  pend_q, pend_d, pend_eff, pend_dec;
  logic [5:0]  cnt_q, cnt_d, cnt_new;
  logic [7:0]  value_q, value_d, value_new;
  logic [7:0]  bg_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  pix_value_q;
  logic [8:0]  pix_x_q;
  logic [7:0]  pix_y_q;
  logic        pix_last_q;
  logic        pix_full_q;

  logic        in_xfer;
  logic        slot_free;
  logic        emit_fire;
  logic        emit_last;

  pos_ctrl_t   pos_ctrl;
  pos_stat_t   pos_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == ST_EMIT) && !pos_stat.done && slot_free;
  // A pixel ends the byte's results when the count runs out or the cell fills.
  assign emit_last  = (cnt_q == 6'd1) || pos_stat.full_next;

  // A start byte abandons any pending run or literal count.
  assign mode_eff = start_cell_i ? MODE_HEADER : mode_q;
  assign pend_eff = start_cell_i ? 7'd0 : pend_q;
  assign pend_dec = pend_eff - 7'd1;

  // Byte parser: works out the new mode and how many pixels this byte causes.
  always_comb begin
    mode_d    = mode_q;
    pend_d    = pend_q;
    cnt_new   = '0;
    value_new = data_byte_i;
    if (in_xfer) begin
      unique case (mode_eff)
        MODE_RUNVAL: begin
          // Run headers carry at most 63, so the low six bits are the count.
          cnt_new = pend_eff[5:0];
          pend_d  = '0;
          mode_d  = MODE_HEADER;
        end
        MODE_LITERAL: begin
          cnt_new = 6'd1;
          pend_d  = pend_dec;
          mode_d  = (pend_dec == '0) ? MODE_HEADER : MODE_LITERAL;
        end
        MODE_HEADER: begin
          if (data_byte_i >= SKIP_HDR_MIN) begin
            cnt_new   = 6'(data_byte_i & SKIP_MASK);
            value_new = bg_q;
            pend_d    = pend_eff;
            mode_d    = MODE_HEADER;
          end else if (data_byte_i >= RUN_HDR_MIN) begin
            pend_d = 7'(data_byte_i & COUNT_MASK);
            mode_d = MODE_RUNVAL;
          end else begin
            pend_d = 7'(data_byte_i & COUNT_MASK);
            mode_d = (pend_d != '0) ? MODE_LITERAL : MODE_HEADER;
          end
        end
        default: begin
          mode_d = MODE_HEADER;
          pend_d = '0;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    value_d = value_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (cnt_new != '0)) begin
          state_d = ST_EMIT;
          cnt_d   = cnt_new;
          value_d = value_new;
        end
      end
      ST_EMIT: begin
        if (pos_stat.done) begin
          // The cell is complete: the rest of the run is dropped.
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else if (slot_free) begin
          cnt_d = cnt_q - 6'd1;
          if (emit_last) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  assign pos_ctrl.clear   = in_xfer && start_cell_i;
  assign pos_ctrl.width   = cell_width_i;
  assign pos_ctrl.height  = cell_height_i;
  assign pos_ctrl.advance = emit_fire;

  crpd_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pos_ctrl),
    .stat_o (pos_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_HEADER;
      pend_q  <= '0;
      cnt_q   <= '0;
      bg_q    <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Output register: lets the next byte transfer while the last pixel waits.
  assign out_valid_d = emit_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      pix_value_q <= value_q;
      pix_x_q     <= pos_stat.col;
      pix_y_q     <= pos_stat.row;
      pix_last_q  <= emit_last;
      pix_full_q  <= pos_stat.full_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pix_value_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign last_of_item_o = pix_last_q;
  assign cell_full_o    = pix_full_q;

  // No pixel is produced once the cell area is complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !pos_stat.done)
    else $error("pixel emitted after cell full");

  // The pixel that fills the cell leaves the position unit marked done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && pos_stat.full_next) |=> pos_stat.done)
    else $error("area not marked done after filling pixel");

  // The last pixel of a byte returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_last) |=> (state_q == ST_IDLE))
    else $error("sequencer still emitting after last pixel");

  // While emitting, pixels remain to be sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("emitting with zero pixel count");

endmodule

// ----- hw/rtl/crpd_pos.sv -----
// ----------------------------------------------------------------------------
// crpd_pos
// Raster position unit: one increment-and-compare step per emitted pixel.
// ----------------------------------------------------------------------------
module crpd_pos import crpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pos_ctrl_t ctrl_i,
  output pos_stat_t stat_o
);

  logic [8:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic [8:0] width_q, width_d;
  logic [7:0] height_q, height_d;
  logic       done_q, done_d;

  logic [9:0] col_inc;
  logic [8:0] row_inc;
  logic       row_end;
  logic       area_end;

  assign col_inc  = {1'b0, col_q} + 10'd1;
  assign row_inc  = {1'b0, row_q} + 9'd1;
  assign row_end  = (col_inc >= {1'b0, width_q});
  assign area_end = row_end && (row_inc >= {1'b0, height_q});

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    width_d  = width_q;
    height_d = height_q;
    done_d   = done_q;
    if (ctrl_i.clear) begin
      col_d  = '0;
      row_d  = '0;
      done_d = 1'b0;
      if (ctrl_i.width == '0) begin
        width_d = 9'd1;
      end else if ({1'b0, ctrl_i.width} > 10'(MAX_WIDTH)) begin
        width_d = 9'(MAX_WIDTH);
      end else begin
        width_d = ctrl_i.width;
      end
      if (ctrl_i.height == '0) begin
        height_d = 8'd1;
      end else if ({1'b0, ctrl_i.height} > 9'(MAX_HEIGHT)) begin
        height_d = 8'(MAX_HEIGHT);
      end else begin
        height_d = ctrl_i.height;
      end
    end else if (ctrl_i.advance && !done_q) begin
      if (row_end) begin
        col_d = '0;
        if (area_end) begin
          row_d  = '0;
          done_d = 1'b1;
        end else begin
          row_d = row_inc[7:0];
        end
      end else begin
        col_d = col_inc[8:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= 9'd1;
      height_q <= 8'd1;
      done_q   <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      width_q  <= width_d;
      height_q <= height_d;
      done_q   <= done_d;
    end
  end

  assign stat_o.col       = col_q;
  assign stat_o.row       = row_q;
  assign stat_o.done      = done_q;
  assign stat_o.full_next = area_end;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cell run-length pixel decoder.
// ----------------------------------------------------------------------------
// Coded bytes are queued by a stimulus sequence, one directed block followed
// by random cells. A driver presents them on the byte channel, and every
// accepted byte is decoded by a behavioral predictor that queues the pixels
// the decoder must emit. A monitor compares every pixel transfer against the
// oldest queued pixel. The background color register is rewritten between
// phases, and only while the decoder is idle. Both channels idle at random
// in the patterns of the phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crpd_pkg::*;

  // Longest run of cycles without any transfer before the run is abandoned.
  localparam int unsigned STALL_LIMIT   = 3000;
  // Quiet cycles after the last pixel, enough for a fully dropped 63-pixel run.
  localparam int unsigned SETTLE_CYCLES = 70;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASE_BYTES   = 58;

  // Parser position of the predictor.
  typedef enum logic [1:0] {
    WANT_HEADER,
    WANT_RUN_VALUE,
    IN_LITERAL
  } parse_e;

  // One coded byte with its side fields, as it travels on the byte channel.
  typedef struct {
    logic       start;
    logic [8:0] width;
    logic [7:0] height;
    logic [7:0] code;
    bit         hold_for_drain;  // wait until every queued pixel has arrived
  } coded_byte_t;

  typedef struct {
    logic [7:0] value;
    logic [8:0] x;
    logic [7:0] y;
    logic       last_of_item;
    logic       cell_full;
  } pixel_t;

  // Every input of the decoder starts at a known value.
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [7:0] cfg_wdata_i    = 8'h00;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic       start_cell_i   = 1'b0;
  logic [8:0] cell_width_i   = 9'd0;
  logic [7:0] cell_height_i  = 8'd0;
  logic [7:0] data_byte_i    = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] pixel_value_o;
  logic [8:0] pixel_x_o;
  logic [7:0] pixel_y_o;
  logic       last_of_item_o;
  logic       cell_full_o;

  cell_rle_pixel_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_cell_i   (start_cell_i),
    .cell_width_i   (cell_width_i),
    .cell_height_i  (cell_height_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_item_o (last_of_item_o),
    .cell_full_o    (cell_full_o)
  );

  // Stimulus and expectation stores.
  coded_byte_t pending_bytes[$];
  pixel_t      expected_pixels[$];
  coded_byte_t on_bus;

  // Predictor state: parser, raster position, held cell size and the register.
  parse_e     parse_state = WANT_HEADER;
  logic [6:0] count_left  = 7'd0;
  logic [8:0] col_now     = 9'd0;
  logic [7:0] row_now     = 8'd0;
  logic [8:0] cell_w      = 9'd1;
  logic [7:0] cell_h      = 8'd1;
  bit         cell_done   = 1'b0;
  logic [7:0] bg_index    = 8'h00;

  // Idle pattern of the current phase, in percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned pixels_checked = 0;
  int unsigned bg_writes      = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Places one pixel at the current raster position unless the cell area is
  // already complete. Returns 1 when a pixel was queued.
  function automatic bit put_pixel(input logic [7:0] value);
    pixel_t px;
    if (cell_done) return 1'b0;
    px.value        = value;
    px.x            = col_now;
    px.y            = row_now;
    px.last_of_item = 1'b0;
    px.cell_full    = 1'b0;
    if (col_now + 9'd1 >= cell_w) begin
      // End of the row: wrap to column 0, and close the cell after the last row.
      col_now = 9'd0;
      if (row_now + 8'd1 >= cell_h) begin
        row_now      = 8'd0;
        cell_done    = 1'b1;
        px.cell_full = 1'b1;
      end else begin
        row_now = row_now + 8'd1;
      end
    end else begin
      col_now = col_now + 9'd1;
    end
    expected_pixels.push_back(px);
    return 1'b1;
  endfunction

  // Decodes one accepted byte and queues the pixels it causes.
  function automatic void decode_coded_byte(input coded_byte_t b);
    int     made;
    pixel_t tail;
    made = 0;
    if (b.start) begin
      // A new cell drops any run or literal count still open.
      parse_state = WANT_HEADER;
      count_left  = 7'd0;
      col_now     = 9'd0;
      row_now     = 8'd0;
      cell_done   = 1'b0;
      if (b.width == 9'd0) cell_w = 9'd1;
      else if (b.width > MAX_WIDTH) cell_w = 9'(MAX_WIDTH);
      else cell_w = b.width;
      if (b.height == 8'd0) cell_h = 8'd1;
      else if (b.height > MAX_HEIGHT) cell_h = 8'(MAX_HEIGHT);
      else cell_h = b.height;
    end
    case (parse_state)
      WANT_RUN_VALUE: begin
        for (int k = 0; k < count_left; k++) made += put_pixel(b.code);
        count_left  = 7'd0;
        parse_state = WANT_HEADER;
      end
      IN_LITERAL: begin
        made += put_pixel(b.code);
        count_left = count_left - 7'd1;
        if (count_left == 7'd0) parse_state = WANT_HEADER;
      end
      default: begin
        if (b.code >= SKIP_HDR_MIN) begin
          for (int k = 0; k < (b.code & SKIP_MASK); k++) made += put_pixel(bg_index);
        end else if (b.code >= RUN_HDR_MIN) begin
          count_left  = 7'(b.code & COUNT_MASK);
          parse_state = WANT_RUN_VALUE;
        end else begin
          count_left  = b.code[6:0];
          parse_state = (count_left != 7'd0) ? IN_LITERAL : WANT_HEADER;
        end
      end
    endcase
    // The final pixel of the byte carries the end marker.
    if (made > 0) begin
      tail = expected_pixels.pop_back();
      tail.last_of_item = 1'b1;
      expected_pixels.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Byte channel driver
  // --------------------------------------------------------------------------
  // The accepted byte is decoded at the edge of its transfer. The next byte is
  // loaded only when the channel is free, so valid and payload hold steady
  // while the decoder stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_coded_byte(on_bus);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_bytes[0].hold_for_drain && expected_pixels.size() != 0)) begin
          on_bus = pending_bytes.pop_front();
          in_valid_i    <= 1'b1;
          start_cell_i  <= on_bus.start;
          cell_width_i  <= on_bus.width;
          cell_height_i <= on_bus.height;
          data_byte_i   <= on_bus.code;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel channel monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t px;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel with none expected: value %h x %0d y %0d last %b full %b",
                     $realtime, pixel_value_o, pixel_x_o, pixel_y_o, last_of_item_o,
                     cell_full_o);
        end else begin
          px = expected_pixels.pop_front();
          if (px.value !== pixel_value_o || px.x !== pixel_x_o || px.y !== pixel_y_o ||
              px.last_of_item !== last_of_item_o || px.cell_full !== cell_full_o) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: pixel mismatch, expected value %h x %0d y %0d last %b full %b",
                       $realtime, px.value, px.x, px.y, px.last_of_item, px.cell_full);
              $display("%0t:                 actual value %h x %0d y %0d last %b full %b",
                       $realtime, pixel_value_o, pixel_x_o, pixel_y_o, last_of_item_o,
                       cell_full_o);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_byte(input logic start, input logic [8:0] w,
                                   input logic [7:0] h, input logic [7:0] code,
                                   input bit hold);
    coded_byte_t it;
    it.start          = start;
    it.width          = w;
    it.height         = h;
    it.code           = code;
    it.hold_for_drain = hold;
    pending_bytes.push_back(it);
    bytes_queued++;
  endfunction

  // Count for a skip or run header: empty and longest runs show up often.
  function automatic int unsigned run_length();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 63;
    if (pick == 1) return 0;
    return $urandom_range(1, 12);
  endfunction

  // Mostly small cells so that many of them fill up; a few large or out of range.
  function automatic void pick_size(output logic [8:0] w, output logic [7:0] h);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 17) begin
      w = 9'($urandom_range(1, 16));
      h = 8'($urandom_range(1, 8));
    end else if (pick < 19) begin
      w = 9'($urandom_range(100, MAX_WIDTH));
      h = 8'($urandom_range(50, MAX_HEIGHT));
    end else begin
      w = 9'($urandom_range(0, 511));
      h = 8'($urandom_range(0, 255));
    end
  endfunction

  // Queues one well-formed cell with random content. Now and then a literal is
  // cut short, a raw byte slips in, or a stray byte precedes the cell.
  function automatic void queue_random_cell(input bit hold);
    logic [7:0]  codes[$];
    logic [8:0]  w;
    logic [7:0]  h;
    int unsigned segs;
    int unsigned kind;
    int unsigned n;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        codes.push_back(SKIP_HDR_MIN | 8'(run_length()));
      end else if (kind <= 5) begin
        codes.push_back(RUN_HDR_MIN | 8'(run_length()));
        codes.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 8) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        codes.push_back(8'(n));
        if (n != 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
        repeat (n) codes.push_back(8'($urandom_range(0, 255)));
      end else begin
        codes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 11) == 0)
      add_byte(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    pick_size(w, h);
    foreach (codes[i]) begin
      if (i == 0) add_byte(1'b1, w, h, codes[i], hold);
      else add_byte(1'b0, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                    codes[i], 1'b0);
    end
  endfunction

  // Waits until every queued byte is taken and every predicted pixel has come,
  // then lets the decoder finish any run whose pixels are all dropped.
  task automatic wait_for_idle();
    while (bytes_accepted != bytes_queued || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_background(input logic [7:0] color);
    cfg_wdata_i <= color;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bg_index = color;
    bg_writes++;
  endtask

  task automatic queue_random_phase(input int unsigned hold_after);
    int unsigned first;
    bit          held;
    first = bytes_queued;
    held  = (hold_after == 0);
    while (bytes_queued - first < PHASE_BYTES) begin
      queue_random_cell(!held && (bytes_queued - first >= hold_after));
      if (bytes_queued - first >= hold_after) held = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: sender idles lightly, receiver stalls heavily.
    send_idle_pct  = 28;
    recv_stall_pct = 59;
    write_background(8'hFF);

    // Directed cells. Right after reset the area is one pixel: a skip of
    // three gives a single pixel that fills the cell, the rest is dropped.
    add_byte(1'b0, 9'd7,   8'd7,   8'hC3, 1'b0);
    // Zero dimensions clamp to one; a literal count of zero emits nothing.
    add_byte(1'b1, 9'd0,   8'd0,   8'h00, 1'b0);
    add_byte(1'b0, 9'd0,   8'd0,   8'hC0, 1'b0);
    // Oversized dimensions clamp to the maximum cell; longest run and skip.
    add_byte(1'b1, 9'd511, 8'd255, 8'hBF, 1'b0);
    add_byte(1'b0, 9'd511, 8'd255, 8'hFF, 1'b0);
    add_byte(1'b0, 9'd0,   8'd0,   8'hFF, 1'b0);
    // An empty run still swallows its value byte.
    add_byte(1'b0, 9'd1,   8'd1,   8'h80, 1'b0);
    add_byte(1'b0, 9'd1,   8'd1,   8'h42, 1'b0);
    // A 5 by 3 cell: a run of twelve wraps over rows, literals finish the area.
    add_byte(1'b1, 9'd5,   8'd3,   8'h8C, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h00, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h03, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h7F, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h80, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h01, 1'b0);
    // Once full, skips and runs are parsed but produce no pixels.
    add_byte(1'b0, 9'd5,   8'd3,   8'hC5, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h84, 1'b0);
    add_byte(1'b0, 9'd5,   8'd3,   8'h33, 1'b0);
    // A new cell in the middle of a run, then in the middle of a literal.
    add_byte(1'b1, 9'd320, 8'd200, 8'h86, 1'b0);
    add_byte(1'b1, 9'd1,   8'd200, 8'h05, 1'b0);
    add_byte(1'b0, 9'd1,   8'd200, 8'hAA, 1'b0);
    add_byte(1'b1, 9'd2,   8'd1,   8'hC4, 1'b0);
    add_byte(1'b1, 9'd3,   8'd2,   8'hC1, 1'b0);
    wait_for_idle();

    write_background(8'h00);
    queue_random_phase(0);
    wait_for_idle();

    // Phase 2: the idle rates swap. One cell waits for a fully drained
    // pixel stream before its first byte goes out.
    send_idle_pct  = 59;
    recv_stall_pct = 28;
    write_background(8'($urandom_range(1, 254)));
    queue_random_phase(35);
    wait_for_idle();

    // Phase 3: both sides run at full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_background(8'hA5);
    queue_random_phase(0);
    wait_for_idle();

    if (expected_pixels.size() != 0) begin
      mismatches++;
      $display("%0d predicted pixels never arrived", expected_pixels.size());
    end

    $display("Decoded %0d coded bytes into %0d checked pixels", bytes_accepted,
             pixels_checked);
    $display("across %0d background colors and three idle patterns, %0d mismatches",
             bg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
